// ----- sv/blhg_pkg.sv -----
// shared types, constants and helpers of the battery level gauge
package blhg_pkg;

    // group size is a power of two, set through its log2 (0 to 6)
    localparam int SAMPLES_LOG2 = 3;
    localparam int SAMPLES      = 1 << SAMPLES_LOG2;

    localparam int SAMPLE_W  = 12;
    localparam int RATIO_W   = 10;
    localparam int MV_W      = 14;
    localparam int HYST_W    = 8;
    localparam int PCT_W     = 7;
    localparam int LVL_W     = 3;
    localparam int NUM_BOUNDS = 4;

    localparam int SUM_W   = SAMPLE_W + SAMPLES_LOG2;
    localparam int COUNT_W = (SAMPLES_LOG2 > 0) ? SAMPLES_LOG2 : 1;
    localparam int PROD_W  = SUM_W + RATIO_W;
    localparam int SHIFT   = SAMPLES_LOG2 + 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    typedef logic [LVL_W-1:0] t_level;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATIO = 3'd0,
        CFG_THR1  = 3'd1,
        CFG_THR2  = 3'd2,
        CFG_THR3  = 3'd3,
        CFG_THR4  = 3'd4,
        CFG_HYST  = 3'd5
    } t_cfg_idx;

    localparam logic [RATIO_W-1:0] RATIO_RST = RATIO_W'(527);
    localparam logic [MV_W-1:0]    THR1_RST  = MV_W'(3000);
    localparam logic [MV_W-1:0]    THR2_RST  = MV_W'(3480);
    localparam logic [MV_W-1:0]    THR3_RST  = MV_W'(3620);
    localparam logic [MV_W-1:0]    THR4_RST  = MV_W'(3820);
    localparam logic [HYST_W-1:0]  HYST_RST  = HYST_W'(30);

    localparam t_level LVL_0 = 3'd0;
    localparam t_level LVL_1 = 3'd1;
    localparam t_level LVL_2 = 3'd2;
    localparam t_level LVL_3 = 3'd3;
    localparam t_level LVL_4 = 3'd4;

    typedef struct packed {
        logic [RATIO_W-1:0]                ratio;
        logic [NUM_BOUNDS-1:0][MV_W-1:0]   thr;
        logic [HYST_W-1:0]                 hyst;
    } t_cfg;

    // completed group handed from the accumulator to the level stage
    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum;
    } t_grp;

    function automatic logic [PCT_W-1:0] level_to_pct(input t_level lvl);
        logic [PCT_W-1:0] pct;
        unique case (lvl)
            LVL_1:   pct = PCT_W'(25);
            LVL_2:   pct = PCT_W'(50);
            LVL_3:   pct = PCT_W'(75);
            LVL_4:   pct = PCT_W'(100);
            default: pct = '0;
        endcase
        return pct;
    endfunction

endpackage

// ----- sv/blhg_ifs.sv -----
// valid/ready channel interfaces of the battery level gauge
interface blhg_in_if;
    logic                          valid;
    logic                          ready;
    logic [blhg_pkg::SAMPLE_W-1:0] sample_mv;

    modport source (output valid, output sample_mv, input ready);
    modport sink   (input valid, input sample_mv, output ready);
endinterface

interface blhg_out_if;
    logic                       valid;
    logic                       ready;
    logic [blhg_pkg::PCT_W-1:0] level_percent;
    logic [blhg_pkg::MV_W-1:0]  battery_mv;

    modport source (output valid, output level_percent, output battery_mv, input ready);
    modport sink   (input valid, input level_percent, input battery_mv, output ready);
endinterface

interface blhg_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [blhg_pkg::CFG_IDX_W-1:0]  index;
    logic [blhg_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/blhg_cfg_regs.sv -----
// configuration register file of the battery level gauge
module blhg_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    blhg_cfg_if.sink           i_cfg,
    output blhg_pkg::t_cfg     o_cfg
);

    blhg_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ratio  <= blhg_pkg::RATIO_RST;
            r_cfg.thr[0] <= blhg_pkg::THR1_RST;
            r_cfg.thr[1] <= blhg_pkg::THR2_RST;
            r_cfg.thr[2] <= blhg_pkg::THR3_RST;
            r_cfg.thr[3] <= blhg_pkg::THR4_RST;
            r_cfg.hyst   <= blhg_pkg::HYST_RST;
        end else if (i_cfg.valid) begin
            // unknown indexes are dropped
            unique case (i_cfg.index)
                blhg_pkg::CFG_RATIO: r_cfg.ratio  <= i_cfg.data[blhg_pkg::RATIO_W-1:0];
                blhg_pkg::CFG_THR1:  r_cfg.thr[0] <= i_cfg.data[blhg_pkg::MV_W-1:0];
                blhg_pkg::CFG_THR2:  r_cfg.thr[1] <= i_cfg.data[blhg_pkg::MV_W-1:0];
                blhg_pkg::CFG_THR3:  r_cfg.thr[2] <= i_cfg.data[blhg_pkg::MV_W-1:0];
                blhg_pkg::CFG_THR4:  r_cfg.thr[3] <= i_cfg.data[blhg_pkg::MV_W-1:0];
                blhg_pkg::CFG_HYST:  r_cfg.hyst   <= i_cfg.data[blhg_pkg::HYST_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ----- sv/blhg_accum.sv -----
// sample accumulator and group hand-off register
module blhg_accum (
    input  logic           i_clk,
    input  logic           i_rst_n,
    blhg_in_if.sink        i_in,
    input  logic           i_grp_ready,
    output blhg_pkg::t_grp o_grp
);

    logic [blhg_pkg::SUM_W-1:0]   r_sum;
    logic [blhg_pkg::COUNT_W-1:0] r_count;
    logic                         r_grp_valid;
    logic [blhg_pkg::SUM_W-1:0]   r_grp_sum;

    logic [blhg_pkg::SUM_W-1:0]   n_sum;
    logic                         w_last;
    logic                         w_accept;

    assign n_sum  = r_sum + blhg_pkg::SUM_W'(i_in.sample_mv);
    assign w_last = (r_count == blhg_pkg::COUNT_W'(blhg_pkg::SAMPLES - 1));

    // hand-off slot must be free or draining
    assign i_in.ready = !r_grp_valid || i_grp_ready;
    assign w_accept   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_count     <= '0;
            r_grp_valid <= 1'b0;
        end else begin
            if (w_accept && w_last) begin
                r_sum       <= '0;
                r_count     <= '0;
                r_grp_valid <= 1'b1;
            end else begin
                if (w_accept) begin
                    r_sum   <= n_sum;
                    r_count <= r_count + blhg_pkg::COUNT_W'(1);
                end
                if (i_grp_ready) begin
                    r_grp_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_last) begin
            r_grp_sum <= n_sum;
        end
    end

    assign o_grp.valid = r_grp_valid;
    assign o_grp.sum   = r_grp_sum;

endmodule

// ----- sv/blhg_level.sv -----
// voltage scaling, level tracking and result register
module blhg_level (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  blhg_pkg::t_cfg i_cfg,
    input  blhg_pkg::t_grp i_grp,
    output logic           o_grp_ready,
    blhg_out_if.source     o_out
);

    logic                         r_out_valid;
    logic [blhg_pkg::PCT_W-1:0]   r_pct;
    logic [blhg_pkg::MV_W-1:0]    r_mv;
    logic                         r_known;
    blhg_pkg::t_level             r_level;

    logic [blhg_pkg::PROD_W-1:0]  w_prod;
    logic [blhg_pkg::MV_W-1:0]    w_mv;
    logic [blhg_pkg::MV_W:0]      w_up [blhg_pkg::NUM_BOUNDS];
    logic [blhg_pkg::NUM_BOUNDS-1:0] w_meet;
    logic [blhg_pkg::NUM_BOUNDS-1:0] w_rise;
    blhg_pkg::t_level             n_level;
    logic                         w_load;

    assign w_prod = blhg_pkg::PROD_W'(i_grp.sum) * blhg_pkg::PROD_W'(i_cfg.ratio);
    // never exceeds 16364, so the low 14 bits after the shift are exact
    assign w_mv   = w_prod[blhg_pkg::SHIFT +: blhg_pkg::MV_W];

    always_comb begin
        for (int i = 0; i < blhg_pkg::NUM_BOUNDS; i++) begin
            w_up[i]   = {1'b0, i_cfg.thr[i]} + (blhg_pkg::MV_W+1)'(i_cfg.hyst);
            w_meet[i] = (w_mv >= i_cfg.thr[i]);
            w_rise[i] = ({1'b0, w_mv} >= w_up[i]);
        end
    end

    always_comb begin
        n_level = r_level;
        if (!r_known) begin
            // highest boundary met wins
            priority if (w_meet[3]) n_level = blhg_pkg::LVL_4;
            else if (w_meet[2])    n_level = blhg_pkg::LVL_3;
            else if (w_meet[1])    n_level = blhg_pkg::LVL_2;
            else if (w_meet[0])    n_level = blhg_pkg::LVL_1;
            else                   n_level = blhg_pkg::LVL_0;
        end else begin
            // drop on lower boundary first, then rise on upper plus margin
            unique case (r_level)
                blhg_pkg::LVL_0: begin
                    if (w_rise[0]) n_level = blhg_pkg::LVL_1;
                end
                blhg_pkg::LVL_1: begin
                    if (!w_meet[0])    n_level = blhg_pkg::LVL_0;
                    else if (w_rise[1]) n_level = blhg_pkg::LVL_2;
                end
                blhg_pkg::LVL_2: begin
                    if (!w_meet[1])    n_level = blhg_pkg::LVL_1;
                    else if (w_rise[2]) n_level = blhg_pkg::LVL_3;
                end
                blhg_pkg::LVL_3: begin
                    if (!w_meet[2])    n_level = blhg_pkg::LVL_2;
                    else if (w_rise[3]) n_level = blhg_pkg::LVL_4;
                end
                blhg_pkg::LVL_4: begin
                    if (!w_meet[3]) n_level = blhg_pkg::LVL_3;
                end
                default: n_level = r_level;
            endcase
        end
    end

    assign o_grp_ready = !r_out_valid || o_out.ready;
    assign w_load      = i_grp.valid && o_grp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_known     <= 1'b0;
            r_level     <= blhg_pkg::LVL_0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_known     <= 1'b1;
                r_level     <= n_level;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_pct <= blhg_pkg::level_to_pct(n_level);
            r_mv  <= w_mv;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.level_percent = r_pct;
    assign o_out.battery_mv    = r_mv;

endmodule

// ----- sv/battery_level_hysteresis_gauge_core.sv -----
// top level of the battery level gauge: accumulator, level stage, config registers
// throughput: one sample word per cycle, sustained while results are taken
// a group's result goes through the group hand-off register, then the result register
// the sample path stalls only when a finished group and a waiting result both block
// reset (synchronous, active low) empties the group sum, forgets the level and
// loads the default divider ratio, thresholds and hysteresis
module battery_level_hysteresis_gauge_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    blhg_in_if.sink    i_in,
    blhg_cfg_if.sink   i_cfg,
    blhg_out_if.source o_out
);

    // live configuration; the user is to write it only while idle, the block does not enforce this
    blhg_pkg::t_cfg w_cfg;
    // completed group sum waiting for the level stage
    blhg_pkg::t_grp w_grp;
    logic           w_grp_ready;

    blhg_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // sums each group of samples, hands the sum over in one register
    blhg_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_grp_ready (w_grp_ready),
        .o_grp       (w_grp)
    );

    // scale by the divider ratio, step the level, hold the result word
    blhg_level u_level (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_grp       (w_grp),
        .o_grp_ready (w_grp_ready),
        .o_out       (o_out)
    );

    // a result only ever carries one of the five level steps
    a_pct_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.level_percent == 7'd0 || o_out.level_percent == 7'd25 ||
                         o_out.level_percent == 7'd50 || o_out.level_percent == 7'd75 ||
                         o_out.level_percent == 7'd100))
        else $error("illegal level percent");

    // a blocked group sum is held until the level stage takes it
    a_grp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_grp.valid && !w_grp_ready |=> w_grp.valid && $stable(w_grp.sum))
        else $error("group sum lost while stalled");

    // the sample path only stalls behind a pending group
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> w_grp.valid && o_out.valid && !o_out.ready)
        else $error("sample path stalled without cause");

    // a result word appears in the cycle after a group hand-off
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_grp.valid && w_grp_ready |=> o_out.valid)
        else $error("group taken but no result");

endmodule

// ----- bench/blhg_checker.sv -----
`timescale 1ns / 1ps
// checker of the battery level gauge: tracks settings and groups, predicts and compares readings
module blhg_checker
    import blhg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    blhg_in_if   i_in,
    blhg_cfg_if  i_cfg,
    blhg_out_if  i_out,
    output int   o_mismatches,
    output int   o_pending
);

    typedef struct packed {
        logic [PCT_W-1:0] pct;
        logic [MV_W-1:0]  mv;
    } t_reading;

    // settings as last written
    logic [RATIO_W-1:0] ratio_r;
    logic [MV_W-1:0]    thr_r [NUM_BOUNDS];
    logic [HYST_W-1:0]  hyst_r;

    // group and level state
    logic [SUM_W-1:0] group_sum;
    int unsigned      group_fill;
    bit               level_seen;
    t_level           level_now;

    t_reading readings_q[$];
    int       mismatch_cnt = 0;

    task automatic apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_RATIO: ratio_r  = val[RATIO_W-1:0];
            CFG_THR1:  thr_r[0] = val[MV_W-1:0];
            CFG_THR2:  thr_r[1] = val[MV_W-1:0];
            CFG_THR3:  thr_r[2] = val[MV_W-1:0];
            CFG_THR4:  thr_r[3] = val[MV_W-1:0];
            CFG_HYST:  hyst_r   = val[HYST_W-1:0];
            default: ;
        endcase
    endtask

    // adds one sample; a full group yields the reading it should produce
    task automatic absorb_sample(input logic [SAMPLE_W-1:0] s);
        logic [31:0] prod;
        logic [31:0] mv;
        t_reading    r;
        bit          moved;
        int          i;
        group_sum  = group_sum + SUM_W'(s);
        group_fill = group_fill + 1;
        if (group_fill == SAMPLES) begin
            prod       = 32'(group_sum) * 32'(ratio_r);
            mv         = prod / (SAMPLES * 256);
            group_sum  = '0;
            group_fill = 0;
            if (!level_seen) begin
                // first group: one above the highest-numbered threshold met
                level_now = LVL_0;
                for (i = 0; i < NUM_BOUNDS; i++)
                    if (mv >= 32'(thr_r[i])) level_now = t_level'(i + 1);
                level_seen = 1'b1;
            end else begin
                // one step at most, lower boundary looked at first
                moved = 1'b0;
                for (i = 0; i < NUM_BOUNDS && !moved; i++) begin
                    if (32'(level_now) == i + 1 && mv < 32'(thr_r[i])) begin
                        level_now = t_level'(i);
                        moved     = 1'b1;
                    end else if (32'(level_now) == i &&
                                 mv >= 32'(thr_r[i]) + 32'(hyst_r)) begin
                        level_now = t_level'(i + 1);
                        moved     = 1'b1;
                    end
                end
            end
            r.pct = PCT_W'(32'(level_now) * 25);
            r.mv  = mv[MV_W-1:0];
            readings_q.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_reading want;
        if (!i_rst_n) begin
            ratio_r    = RATIO_RST;
            thr_r[0]   = THR1_RST;
            thr_r[1]   = THR2_RST;
            thr_r[2]   = THR3_RST;
            thr_r[3]   = THR4_RST;
            hyst_r     = HYST_RST;
            group_sum  = '0;
            group_fill = 0;
            level_seen = 1'b0;
            level_now  = LVL_0;
            readings_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                apply_setting(i_cfg.index, i_cfg.data);
            if (i_in.valid && i_in.ready)
                absorb_sample(i_in.sample_mv);
            if (i_out.valid && i_out.ready) begin
                if (readings_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: reading with none pending: pct %0d mv %0d",
                                 $realtime, i_out.level_percent, i_out.battery_mv);
                end else begin
                    want = readings_q.pop_front();
                    if (i_out.level_percent !== want.pct || i_out.battery_mv !== want.mv) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("%0t: reading mismatch: expected pct %0d mv %0d, got pct %0d mv %0d",
                                     $realtime, want.pct, want.mv,
                                     i_out.level_percent, i_out.battery_mv);
                    end
                end
            end
        end
        o_pending    <= readings_q.size();
        o_mismatches <= mismatch_cnt;
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// top of the battery level gauge bench: clock, reset, sample and settings stimulus, verdict
module testbench;
    import blhg_pkg::*;

    localparam int DIRECTED_WORDS = 24;
    localparam int RANDOM_WORDS   = 500;
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off, fills the core
    localparam int QUIET_LIMIT    = 4000;  // cycles with no word moving anywhere
    localparam int SETTLE_CYCLES  = 8;     // room after the last sample for any result to settle
    localparam int CFG_PAUSE      = 4;

    // register indexes the core does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic i_clk;
    logic i_rst_n;

    blhg_in_if  in_ch ();
    blhg_cfg_if cfg_ch ();
    blhg_out_if out_ch ();

    int mismatches;
    int readings_pending;

    bit idle_off;          // phase with no gaps on either side
    int hold_req = 0;      // hold-off length asked of the receiver
    int hold_left = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int samples_sent = 0;

    battery_level_hysteresis_gauge_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    blhg_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_cfg        (cfg_ch),
        .i_out        (out_ch),
        .o_mismatches (mismatches),
        .o_pending    (readings_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog: no sample, reading or setting word moved for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // gap length: mostly a few cycles, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // reading side: random stalls, plus the long hold-off when asked
    initial begin
        out_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                out_ch.ready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                out_ch.ready = 1'b0;
                stall_left--;
            end else if (!idle_off && $urandom_range(0, 99) < 25) begin
                out_ch.ready = 1'b0;
                stall_left   = idle_len() - 1;
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    // one settings word; called and returns at a falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // one sample word after an optional gap; valid stays up for a back-to-back word
    task automatic push_sample(input int v);
        int gap;
        gap = 0;
        if (!idle_off && $urandom_range(0, 99) < 35) gap = idle_len();
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.sample_mv = SAMPLE_W'(v);
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        samples_sent++;
    endtask

    // all readings back, then a few cycles so any partial work settles
    task automatic drain_and_settle(input int cycles);
        in_ch.valid = 1'b0;
        while (readings_pending != 0) @(negedge i_clk);
        repeat (cycles) @(negedge i_clk);
    endtask

    // a fresh set of settings, extremes included; upper data bits are junk to be masked
    task automatic load_random_settings();
        int thr_q[$];
        int ratio;
        int hyst;
        int mode;
        int n;
        n = $urandom_range(0, 9);
        if (n == 0)      ratio = 0;
        else if (n == 1) ratio = $urandom_range(1, 255);
        else if (n == 2) ratio = 1023;
        else             ratio = $urandom_range(256, 1023);
        write_reg(CFG_RATIO, {4'($urandom_range(0, 15)), 10'(ratio)});

        // mostly ascending thresholds over the voltage range, sometimes rails or anything
        mode = $urandom_range(0, 9);
        for (n = 0; n < NUM_BOUNDS; n++) begin
            if (mode < 8)       thr_q.push_back($urandom_range(0, 8429));
            else if (mode == 8) thr_q.push_back($urandom_range(0, 1) ? 16383 : 0);
            else                thr_q.push_back($urandom_range(0, 16383));
        end
        if (mode < 8) thr_q.sort();
        write_reg(CFG_THR1, 14'(thr_q[0]));
        write_reg(CFG_THR2, 14'(thr_q[1]));
        write_reg(CFG_THR3, 14'(thr_q[2]));
        write_reg(CFG_THR4, 14'(thr_q[3]));

        n = $urandom_range(0, 5);
        if (n == 0)      hyst = 0;
        else if (n == 1) hyst = 255;
        else             hyst = $urandom_range(0, 255);
        write_reg(CFG_HYST, {6'($urandom_range(0, 63)), 8'(hyst)});

        // an undecoded index now and then, must change nothing
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, 14'($urandom()));
    endtask

    initial begin
        int  phase_no;
        int  groups;
        int  extra;
        int  g;
        int  s;
        int  walk;
        int  v;
        bit  noisy;

        i_rst_n         = 1'b0;
        idle_off        = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.sample_mv = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_RATIO;
        cfg_ch.data     = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: unordered thresholds on the first group, largest ratio (masked
        // from an all-ones word), undecoded indexes ignored
        write_reg(CFG_RATIO, 14'h3FFF);
        write_reg(CFG_THR1, 14'd9000);
        write_reg(CFG_THR2, 14'd100);
        write_reg(CFG_THR3, 14'h3FFF);
        write_reg(CFG_THR4, 14'd5000);
        write_reg(CFG_HYST, 14'h3FFF);
        write_reg(CFG_SPARE_LO, 14'h0000);
        write_reg(CFG_SPARE_HI, 14'h3FFF);

        // full-scale group: top voltage, level from the highest-numbered threshold met
        for (s = 0; s < SAMPLES; s++) push_sample(4095);
        // zero group: drop one step
        for (s = 0; s < SAMPLES; s++) push_sample(0);
        drain_and_settle(CFG_PAUSE);

        // unity ratio, zero hysteresis, voltage sitting exactly on two boundaries
        write_reg(CFG_RATIO, 14'd256);
        write_reg(CFG_THR1, 14'd0);
        write_reg(CFG_THR2, 14'd1000);
        write_reg(CFG_THR3, 14'd2047);
        write_reg(CFG_THR4, 14'd2047);
        write_reg(CFG_HYST, 14'd0);
        for (s = 0; s < SAMPLES; s++) push_sample(s[0] ? 12'h555 : 12'hAAA);

        // random phases: settings between phases, groups following a drifting level
        phase_no = 0;
        walk     = $urandom_range(0, 4095);
        while (samples_sent < DIRECTED_WORDS + RANDOM_WORDS) begin
            drain_and_settle(CFG_PAUSE);
            load_random_settings();
            idle_off = ($urandom_range(0, 4) == 0);
            groups   = $urandom_range(1, 6);
            if (phase_no == 1) begin
                // receiver holds off while samples keep coming, core backs up
                hold_req = HOLD_CYCLES;
                idle_off = 1'b1;
                groups   = 6;
            end
            extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
            for (g = 0; g < groups; g++) begin
                noisy = ($urandom_range(0, 6) == 0);
                walk  = walk + int'($urandom_range(0, 600)) - 300;
                if (walk < 0) walk = 0;
                if (walk > 4095) walk = 4095;
                for (s = 0; s < SAMPLES; s++) begin
                    if (noisy) begin
                        v = $urandom_range(0, 4095);
                    end else begin
                        v = walk + int'($urandom_range(0, 40)) - 20;
                        if (v < 0) v = 0;
                        if (v > 4095) v = 4095;
                    end
                    push_sample(v);
                end
            end
            // partial group carried into the next phase
            for (s = 0; s < extra; s++) push_sample($urandom_range(0, 4095));
            phase_no++;
        end

        drain_and_settle(SETTLE_CYCLES);
        if (mismatches == 0 && readings_pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- battery_level_hysteresis_gauge_core.f -----
sv/blhg_pkg.sv
sv/blhg_ifs.sv
sv/blhg_cfg_regs.sv
sv/blhg_accum.sv
sv/blhg_level.sv
sv/battery_level_hysteresis_gauge_core.sv
bench/blhg_checker.sv
bench/testbench.sv
